// ===== design/pbpc_pkg.sv =====
// shared types and constants of the pulse baseline, peak and charge unit
package pbpc_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 12;
    localparam int BASELINE_W  = 16;
    localparam int PEAK_W      = 12;
    localparam int AMP_W       = 17;
    localparam int SUM_W       = 22;
    localparam int REMOVED_W   = 8;
    localparam int COUNT_W     = 8;
    localparam int THR_W       = 4;
    localparam int FRAC_BITS   = 4;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SIGMA = 1'd1;

    localparam logic [COUNT_W-1:0] BASE_COUNT_RESET = 8'd71;
    localparam logic [THR_W-1:0]   THR_RESET        = 4'd5;

    // controller states
    typedef enum logic [2:0] {
        ST_RUN,
        ST_PREP_MUL,
        ST_PREP_SUB,
        ST_PREP_SCALE,
        ST_WALK,
        ST_DRAIN,
        ST_DIV,
        ST_FIN
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic prep_mul;
        logic prep_sub;
        logic prep_scale;
        logic walk_issue;
        logic div_start;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic record_end;
        logic walk_last;
        logic walk_busy;
        logic div_done;
    } sts_t;

endpackage

// ===== design/pulse_baseline_peak_charge_unit.sv =====
// top level of the pulse baseline, peak and charge unit
//
// channel  direction  handshake           payload
// s_       in         s_valid / s_ready   s_sample
// m_       out        m_valid / m_ready   m_baseline, m_peak_sample, m_amplitude,
//                                         m_sample_sum, m_removed_count
// cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
// one sample transaction per cycle inside a record of RECORD_LEN samples
// after the last sample the input stalls for the end-of-record sequence:
// variance products, a rejection walk of N samples (N = baseline length) over the store
// read port, the walk pipeline drain and a bit-serial divide of one bit a cycle
// the result sits in an output register, so the next record streams in while it waits
// reset is synchronous and active low; it sets the baseline length to 71 and the limit to 5
module pulse_baseline_peak_charge_unit #(
    parameter int MAX_BASE   = 128,
    parameter int RECORD_LEN = 1024
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [pbpc_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [pbpc_pkg::BASELINE_W-1:0]  m_baseline,
    output logic signed [pbpc_pkg::PEAK_W-1:0]      m_peak_sample,
    output logic signed [pbpc_pkg::AMP_W-1:0]       m_amplitude,
    output logic signed [pbpc_pkg::SUM_W-1:0]       m_sample_sum,
    output logic        [pbpc_pkg::REMOVED_W-1:0]   m_removed_count,
    input  logic                                    cfg_wr_en,
    input  logic        [pbpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [pbpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [pbpc_pkg::COUNT_W-1:0] base_count_reg;
    logic [pbpc_pkg::THR_W-1:0]   threshold_reg;
    pbpc_pkg::cmd_t               cmd;
    pbpc_pkg::sts_t               sts;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_count_reg <= pbpc_pkg::BASE_COUNT_RESET;
            threshold_reg  <= pbpc_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pbpc_pkg::REG_BASELINE_COUNT: begin
                    base_count_reg <= cfg_wdata[pbpc_pkg::COUNT_W-1:0];
                end
                pbpc_pkg::REG_THRESHOLD_SIGMA: begin
                    threshold_reg <= cfg_wdata[pbpc_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // controller
    pbpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath
    pbpc_dp #(
        .MAX_BASE   (MAX_BASE),
        .RECORD_LEN (RECORD_LEN)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_base_count  (base_count_reg),
        .cfg_threshold   (threshold_reg),
        .s_sample        (s_sample),
        .m_baseline      (m_baseline),
        .m_peak_sample   (m_peak_sample),
        .m_amplitude     (m_amplitude),
        .m_sample_sum    (m_sample_sum),
        .m_removed_count (m_removed_count)
    );

endmodule

// ===== design/pbpc_div.sv =====
// bit-serial signed floor divider with unsigned divisor
module pbpc_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic              neg_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic signed [NUM_W-1:0] quot_reg;

    logic [NUM_W-1:0]  mag;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // magnitude of the dividend
    assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // one restoring step
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift registers and floor correction
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NUM_W-1];
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= mag;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
            end else if (neg_reg) begin
                // negative dividend rounds down when a remainder is left
                quot_reg <= (rem_reg != '0) ? $signed(~quo_reg) : $signed(-quo_reg);
            end else begin
                quot_reg <= $signed(quo_reg);
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/pbpc_dp.sv =====
// datapath: sample intake, baseline store, rejection walk, divider and result register
module pbpc_dp #(
    parameter int MAX_BASE   = 128,
    parameter int RECORD_LEN = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pbpc_pkg::cmd_t                        cmd,
    output pbpc_pkg::sts_t                        sts,
    input  logic        [pbpc_pkg::COUNT_W-1:0]   cfg_base_count,
    input  logic        [pbpc_pkg::THR_W-1:0]     cfg_threshold,
    input  logic signed [pbpc_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic signed [pbpc_pkg::BASELINE_W-1:0] m_baseline,
    output logic signed [pbpc_pkg::PEAK_W-1:0]    m_peak_sample,
    output logic signed [pbpc_pkg::AMP_W-1:0]     m_amplitude,
    output logic signed [pbpc_pkg::SUM_W-1:0]     m_sample_sum,
    output logic        [pbpc_pkg::REMOVED_W-1:0] m_removed_count
);

    localparam int SB    = pbpc_pkg::SAMPLE_BITS;
    localparam int N_MAX = (MAX_BASE < RECORD_LEN) ? MAX_BASE : RECORD_LEN;
    localparam int CNT_W = $clog2(N_MAX + 1);
    localparam int AW    = $clog2(MAX_BASE);
    localparam int PW    = $clog2(RECORD_LEN);
    localparam int SW    = SB + CNT_W;
    localparam int QW    = 2 * SB - 1 + CNT_W;
    localparam int NQW   = CNT_W + QW;
    localparam int KW    = 2 * pbpc_pkg::THR_W;
    localparam int SPW   = NQW + KW;
    localparam int DW    = SB + CNT_W + 2;
    localparam int DDW   = 2 * DW;
    localparam int CMPW  = (SPW > DDW) ? SPW : DDW;
    localparam int NUM_W = SW + pbpc_pkg::FRAC_BITS;
    localparam int RSW   = pbpc_pkg::SUM_W;

    // baseline store
    logic signed [SB-1:0] store_mem [MAX_BASE];

    logic [PW-1:0]           pos_reg;
    logic [CNT_W-1:0]        n_reg;
    logic signed [SW-1:0]    sum_reg;
    logic [QW-1:0]           q_reg;
    logic signed [SB-1:0]    peak_reg;
    logic signed [RSW-1:0]   rsum_reg;

    logic [NQW-1:0]          nq_reg;
    logic [2*SW-1:0]         ss_reg;
    logic [NQW-1:0]          var_reg;
    logic [SPW-1:0]          spread_reg;

    logic [AW-1:0]           walk_idx_reg;
    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [SB-1:0]    rd_reg, rd2_reg, rd3_reg;
    logic signed [DW-1:0]    d_reg;
    logic [DDW-1:0]          dd_reg;
    logic signed [SW-1:0]    kept_reg;
    logic [CNT_W-1:0]        drop_reg;

    logic signed [pbpc_pkg::BASELINE_W-1:0] base_out_reg;
    logic signed [pbpc_pkg::PEAK_W-1:0]     peak_out_reg;
    logic signed [pbpc_pkg::AMP_W-1:0]      amp_out_reg;
    logic signed [RSW-1:0]                  rsum_out_reg;
    logic [pbpc_pkg::REMOVED_W-1:0]         removed_out_reg;

    logic                    first;
    logic [CNT_W-1:0]        n_clamp;
    logic [CNT_W-1:0]        n_cur;
    logic                    store_en;
    logic signed [SW-1:0]    sum_base;
    logic [QW-1:0]           q_base;
    logic signed [SB-1:0]    peak_base;
    logic signed [RSW-1:0]   rsum_base;
    logic signed [SB:0]      x_ext, p_ext;
    logic [SB:0]             mag_x, mag_p;
    logic signed [2*SB-1:0]  sq;
    logic signed [2*SW-1:0]  ss;
    logic [2*SW-1:0]         var_full;
    logic [KW-1:0]           k2;
    logic signed [SB+CNT_W:0] nr;
    logic signed [DW-1:0]    d_next;
    logic signed [DDW-1:0]   dd;
    logic                    drop_hit;
    logic                    use_kept;
    logic signed [NUM_W-1:0] div_num;
    logic [CNT_W-1:0]        div_den;
    logic                    div_done;
    logic signed [NUM_W-1:0] base16;
    logic signed [NUM_W:0]   peak16;
    logic signed [NUM_W:0]   amp_full;

    // baseline length, clamped, taken at the start of a record
    always_comb begin
        if (cfg_base_count < 8'd2) begin
            n_clamp = CNT_W'(2);
        end else if (32'(cfg_base_count) > N_MAX) begin
            n_clamp = CNT_W'(N_MAX);
        end else begin
            n_clamp = CNT_W'(cfg_base_count);
        end
    end

    // per-sample accumulation terms
    assign first     = (pos_reg == '0);
    assign n_cur     = first ? n_clamp : n_reg;
    assign store_en  = cmd.accept && (32'(pos_reg) < 32'(n_cur));
    assign sum_base  = first ? '0 : sum_reg;
    assign q_base    = first ? '0 : q_reg;
    assign peak_base = first ? '0 : peak_reg;
    assign rsum_base = first ? '0 : rsum_reg;
    assign x_ext     = {s_sample[SB-1], s_sample};
    assign p_ext     = {peak_base[SB-1], peak_base};
    assign mag_x     = x_ext[SB] ? (SB+1)'(-x_ext) : (SB+1)'(x_ext);
    assign mag_p     = p_ext[SB] ? (SB+1)'(-p_ext) : (SB+1)'(p_ext);
    assign sq        = s_sample * s_sample;

    // record position and length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.accept) begin
            pos_reg <= sts.record_end ? '0 : pos_reg + 1'b1;
        end
    end

    // sums, peak and store writes
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (first) begin
                n_reg <= n_clamp;
            end
            if (store_en) begin
                store_mem[pos_reg[AW-1:0]] <= s_sample;
                sum_reg <= sum_base + SW'(s_sample);
                q_reg   <= q_base + QW'(sq);
            end else begin
                sum_reg <= sum_base;
                q_reg   <= q_base;
            end
            peak_reg <= (mag_x > mag_p) ? s_sample : peak_base;
            rsum_reg <= rsum_base + RSW'(s_sample);
        end
    end

    // variance limit k^2 * (N*Q - S^2), three steps
    assign ss       = sum_reg * sum_reg;
    assign var_full = {1'b0, nq_reg} - ss_reg;
    assign k2       = cfg_threshold * cfg_threshold;

    always_ff @(posedge aclk) begin
        if (cmd.prep_mul) begin
            nq_reg <= n_reg * q_reg;
            ss_reg <= ss;
        end
        if (cmd.prep_sub) begin
            var_reg <= var_full[NQW-1:0];
        end
        if (cmd.prep_scale) begin
            spread_reg <= k2 * var_reg;
        end
    end

    // rejection walk: read, deviation, square, compare
    assign nr       = $signed({1'b0, n_reg}) * rd_reg;
    assign d_next   = DW'(nr) - DW'(sum_reg);
    assign dd       = d_reg * d_reg;
    assign drop_hit = (CMPW'(dd_reg) > CMPW'(spread_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.walk_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep_mul) begin
            walk_idx_reg <= '0;
        end else if (cmd.walk_issue) begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
        if (cmd.walk_issue) begin
            rd_reg <= store_mem[walk_idx_reg];
        end
        d_reg   <= d_next;
        rd2_reg <= rd_reg;
        dd_reg  <= dd;
        rd3_reg <= rd2_reg;
    end

    // kept sum and outlier count
    always_ff @(posedge aclk) begin
        if (cmd.prep_mul) begin
            kept_reg <= '0;
            drop_reg <= '0;
        end else if (v3_reg) begin
            if (drop_hit) begin
                drop_reg <= drop_reg + 1'b1;
            end else begin
                kept_reg <= kept_reg + SW'(rd3_reg);
            end
        end
    end

    // mean of kept samples, plain mean when all are dropped
    assign use_kept = (drop_reg < n_reg);
    assign div_num  = use_kept ? $signed({kept_reg, 4'b0000}) : $signed({sum_reg, 4'b0000});
    assign div_den  = use_kept ? (n_reg - drop_reg) : n_reg;

    pbpc_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (base16)
    );

    // result register
    assign peak16   = $signed({{(NUM_W + 1 - SB - 4){peak_reg[SB-1]}}, peak_reg, 4'b0000});
    assign amp_full = peak16 - (NUM_W+1)'(base16);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            base_out_reg    <= base16[pbpc_pkg::BASELINE_W-1:0];
            peak_out_reg    <= peak_reg;
            amp_out_reg     <= amp_full[pbpc_pkg::AMP_W-1:0];
            rsum_out_reg    <= rsum_reg;
            removed_out_reg <= pbpc_pkg::REMOVED_W'(drop_reg);
        end
    end

    // status
    assign sts.record_end = (pos_reg == PW'(RECORD_LEN - 1));
    assign sts.walk_last  = ((32'(walk_idx_reg) + 32'd1) == 32'(n_reg));
    assign sts.walk_busy  = v1_reg | v2_reg | v3_reg;
    assign sts.div_done   = div_done;

    assign m_baseline      = base_out_reg;
    assign m_peak_sample   = peak_out_reg;
    assign m_amplitude     = amp_out_reg;
    assign m_sample_sum    = rsum_out_reg;
    assign m_removed_count = removed_out_reg;

endmodule

// ===== design/pbpc_ctrl.sv =====
// controller state machine: record intake, end-of-record sequence and result hand-off
module pbpc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  pbpc_pkg::sts_t  sts,
    output pbpc_pkg::cmd_t  cmd
);

    pbpc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // state and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pbpc_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            pbpc_pkg::ST_RUN: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && sts.record_end) begin
                    state_next = pbpc_pkg::ST_PREP_MUL;
                end
            end
            pbpc_pkg::ST_PREP_MUL: begin
                cmd.prep_mul = 1'b1;
                state_next   = pbpc_pkg::ST_PREP_SUB;
            end
            pbpc_pkg::ST_PREP_SUB: begin
                cmd.prep_sub = 1'b1;
                state_next   = pbpc_pkg::ST_PREP_SCALE;
            end
            pbpc_pkg::ST_PREP_SCALE: begin
                cmd.prep_scale = 1'b1;
                state_next     = pbpc_pkg::ST_WALK;
            end
            pbpc_pkg::ST_WALK: begin
                cmd.walk_issue = 1'b1;
                if (sts.walk_last) begin
                    state_next = pbpc_pkg::ST_DRAIN;
                end
            end
            pbpc_pkg::ST_DRAIN: begin
                if (!sts.walk_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = pbpc_pkg::ST_DIV;
                end
            end
            pbpc_pkg::ST_DIV: begin
                if (sts.div_done) begin
                    state_next = pbpc_pkg::ST_FIN;
                end
            end
            pbpc_pkg::ST_FIN: begin
                // wait until the result register is free
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = pbpc_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = pbpc_pkg::ST_RUN;
            end
        endcase
    end

    // result valid held until the transaction completes
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of the pulse baseline, peak and charge unit
module testbench;
    import pbpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RECORD_LEN        = 1024;
    localparam int MAX_BASE          = 128;
    localparam int SETTLE_CYCLES     = MAX_BASE + 64;
    localparam int HOLD_CYCLES       = 3 * RECORD_LEN;
    localparam int RANDOM_PHASES     = 8;
    localparam int RECORDS_PER_PHASE = 5;
    localparam int IDLE_PERCENT      = 17;
    localparam longint TIMEOUT_NS    = 4_000_000;

    typedef enum {REC_PULSE, REC_NOISE, REC_CONST, REC_TWO_LEVEL, REC_TIES} record_kind_t;

    typedef struct packed {
        logic signed [BASELINE_W-1:0] baseline;
        logic signed [PEAK_W-1:0]     peak_sample;
        logic signed [AMP_W-1:0]      amplitude;
        logic signed [SUM_W-1:0]      sample_sum;
        logic [REMOVED_W-1:0]         removed_count;
    } charge_result_t;

    // predicts one result per record and checks the block against it
    class charge_scoreboard;
        int unsigned    errors;
        int unsigned    records;
        int unsigned    samples;
        int unsigned    outliers_total;
        int unsigned    all_rejected;
        charge_result_t expected_q[$];
        longint         base_mem[MAX_BASE];
        int unsigned    position;
        int unsigned    base_len;
        int unsigned    count_reg;
        int unsigned    sigma_reg;
        longint         base_sum;
        longint         square_sum;
        longint         peak_val;
        longint         record_total;

        function new();
            count_reg = BASE_COUNT_RESET;
            sigma_reg = THR_RESET;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_BASELINE_COUNT) begin
                count_reg = data;
            end else begin
                count_reg = count_reg;
                sigma_reg = data[THR_W-1:0];
            end
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
            longint         x;
            longint         n;
            longint         spread;
            longint         dev;
            longint         kept;
            longint         num;
            longint         den;
            longint         base16;
            longint         amp;
            int unsigned    drops;
            int unsigned    i;
            charge_result_t r;
            x = s;
            samples++;
            // baseline length is latched at the start of each record
            if (position == 0) begin
                base_len = (count_reg < 2) ? 2 : ((count_reg > MAX_BASE) ? MAX_BASE : count_reg);
                base_sum = 0;
                square_sum = 0;
                peak_val = 0;
                record_total = 0;
            end
            if (position < base_len) begin
                base_mem[position] = x;
                base_sum += x;
                square_sum += x * x;
            end
            // first sample of largest magnitude wins
            if ((x < 0 ? -x : x) > (peak_val < 0 ? -peak_val : peak_val))
                peak_val = x;
            record_total += x;
            if (position + 1 < RECORD_LEN) begin
                position++;
                return;
            end
            position = 0;

            // outlier rejection against k standard deviations
            n = base_len;
            spread = longint'(sigma_reg * sigma_reg) * (n * square_sum - base_sum * base_sum);
            kept = 0;
            drops = 0;
            for (i = 0; i < base_len; i++) begin
                dev = n * base_mem[i] - base_sum;
                if (dev * dev > spread)
                    drops++;
                else
                    kept += base_mem[i];
            end

            // floor division, plain mean when everything was rejected
            num = (drops < base_len) ? kept * 16 : base_sum * 16;
            den = (drops < base_len) ? n - drops : n;
            base16 = num / den;
            if (num % den != 0 && num < 0)
                base16--;
            amp = peak_val * 16 - base16;

            r.baseline = base16[BASELINE_W-1:0];
            r.peak_sample = peak_val[PEAK_W-1:0];
            r.amplitude = amp[AMP_W-1:0];
            r.sample_sum = record_total[SUM_W-1:0];
            r.removed_count = drops[REMOVED_W-1:0];
            expected_q.push_back(r);
            outliers_total += drops;
            if (drops == base_len)
                all_rejected++;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch at result %0d: %s got %0d expected %0d", records, what, got, want);
            errors++;
        endtask

        task check_result(charge_result_t got);
            charge_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing pending, baseline", got.baseline, 0);
                return;
            end
            want = expected_q.pop_front();
            records++;
            if (got.baseline !== want.baseline)
                report_mismatch("baseline", got.baseline, want.baseline);
            if (got.peak_sample !== want.peak_sample)
                report_mismatch("peak_sample", got.peak_sample, want.peak_sample);
            if (got.amplitude !== want.amplitude)
                report_mismatch("amplitude", got.amplitude, want.amplitude);
            if (got.sample_sum !== want.sample_sum)
                report_mismatch("sample_sum", got.sample_sum, want.sample_sum);
            if (got.removed_count !== want.removed_count)
                report_mismatch("removed_count", got.removed_count, want.removed_count);
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [BASELINE_W-1:0]  m_baseline;
    logic signed [PEAK_W-1:0]      m_peak_sample;
    logic signed [AMP_W-1:0]       m_amplitude;
    logic signed [SUM_W-1:0]       m_sample_sum;
    logic [REMOVED_W-1:0]          m_removed_count;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_wdata = '0;

    charge_scoreboard sb;
    charge_result_t   seen;
    bit               steady = 1'b0;
    int unsigned      hold_requests = 0;
    int unsigned      hold_served = 0;
    int unsigned      settings = 1;

    pulse_baseline_peak_charge_unit #(
        .MAX_BASE   (MAX_BASE),
        .RECORD_LEN (RECORD_LEN)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_baseline      (m_baseline),
        .m_peak_sample   (m_peak_sample),
        .m_amplitude     (m_amplitude),
        .m_sample_sum    (m_sample_sum),
        .m_removed_count (m_removed_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // clock
    always #2 aclk = ~aclk;

    // one sample transaction, with random idle cycles in front
    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(value);
    endtask

    // one full record of a given waveform shape
    task automatic send_record(input record_kind_t kind, input int level);
        int v;
        int p;
        int noise;
        int t0;
        int height;
        int step;
        int sgn;
        noise = $urandom_range(0, 24);
        t0 = $urandom_range(MAX_BASE + 8, RECORD_LEN - 80);
        height = int'($urandom_range(0, 6000)) - 3000;
        step = $urandom_range(1, 400);
        sgn = $urandom_range(1) ? 1 : -1;
        for (p = 0; p < RECORD_LEN; p++) begin
            case (kind)
                REC_CONST: begin
                    v = level;
                end
                REC_NOISE: begin
                    v = int'($urandom_range(0, 4095)) - 2048;
                end
                REC_TWO_LEVEL: begin
                    v = p[0] ? level + step : level;
                end
                REC_TIES: begin
                    // equal magnitudes of opposite sign, the earlier one must win
                    if (p == 300)
                        v = 1500 * sgn;
                    else if (p == 500)
                        v = -1500 * sgn;
                    else
                        v = int'($urandom_range(0, 6)) - 3;
                end
                default: begin
                    // noisy baseline with sparse spikes, then a fast-rise slow-fall pulse
                    v = level + int'($urandom_range(0, 2 * noise)) - noise;
                    if (p < MAX_BASE && $urandom_range(99) < 4)
                        v += int'($urandom_range(0, 3000)) - 1500;
                    if (p >= t0 && p < t0 + 4)
                        v += height * (p - t0 + 1) / 4;
                    else if (p >= t0 + 4 && p < t0 + 64)
                        v += height * (t0 + 64 - p) / 60;
                end
            endcase
            if (v > 2047)
                v = 2047;
            if (v < -2048)
                v = -2048;
            push_sample(v[SAMPLE_BITS-1:0]);
        end
    endtask

    // stop sending and wait for every pending result plus the tail of the block's work
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // new register setting, written only while the block is idle
    task automatic change_setting(input int count, input int thr);
        drain_results();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BASELINE_COUNT;
        cfg_wdata <= count[CFG_DATA_W-1:0];
        sb.write_register(REG_BASELINE_COUNT, count[CFG_DATA_W-1:0]);
        @(negedge aclk);
        cfg_index <= REG_THRESHOLD_SIGMA;
        cfg_wdata <= thr[CFG_DATA_W-1:0];
        sb.write_register(REG_THRESHOLD_SIGMA, thr[CFG_DATA_W-1:0]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // result side: random ready, with long hold-offs on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_served++;
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // check every accepted result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen = {m_baseline, m_peak_sample, m_amplitude, m_sample_sum, m_removed_count};
            sb.check_result(seen);
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus
    initial begin
        int          phase;
        int          rec;
        int          pick;
        int          count;
        record_kind_t kind;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed records at the reset setting: sum and peak extremes, all zero, ties
        send_record(REC_CONST, -2048);
        send_record(REC_CONST, 2047);
        send_record(REC_CONST, 0);
        send_record(REC_TIES, 0);
        send_record(REC_PULSE, 100);

        // baseline length below the minimum, zero threshold: all rejected, or none at zero variance
        change_setting(0, 0);
        send_record(REC_TWO_LEVEL, 300);
        send_record(REC_CONST, -5);
        send_record(REC_PULSE, -700);

        change_setting(1, 15);
        send_record(REC_PULSE, 0);
        send_record(REC_TWO_LEVEL, -1000);

        // baseline length above the store depth
        change_setting(255, 1);
        send_record(REC_PULSE, 50);
        send_record(REC_NOISE, 0);

        change_setting(128, 15);
        send_record(REC_PULSE, -300);

        change_setting(129, 0);
        send_record(REC_TWO_LEVEL, 1900);
        send_record(REC_PULSE, 1200);

        change_setting(2, 3);
        send_record(REC_PULSE, -1500);

        // random settings and waveforms
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick = $urandom_range(3);
            if (pick == 0)
                count = $urandom_range(0, 8);
            else if (pick == 1)
                count = $urandom_range(120, 255);
            else
                count = $urandom_range(0, 255);
            change_setting(count, $urandom_range(0, 15));
            steady = (phase == 4);
            // long result hold-off while records keep coming, so the input backs up
            if (phase == 1)
                hold_requests++;
            for (rec = 0; rec < RECORDS_PER_PHASE; rec++) begin
                pick = $urandom_range(99);
                if (pick < 65)
                    kind = REC_PULSE;
                else if (pick < 80)
                    kind = REC_NOISE;
                else if (pick < 88)
                    kind = REC_CONST;
                else
                    kind = REC_TWO_LEVEL;
                send_record(kind, int'($urandom_range(0, 3000)) - 1500);
            end
        end
        steady = 1'b0;

        drain_results();
        $display("covered %0d records (%0d samples) over %0d register settings",
                 sb.records, sb.samples, settings);
        $display("%0d baseline samples rejected as outliers, %0d records with all rejected",
                 sb.outliers_total, sb.all_rejected);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pbpc_pkg.sv
design/pbpc_div.sv
design/pbpc_dp.sv
design/pbpc_ctrl.sv
design/pulse_baseline_peak_charge_unit.sv
test/testbench.sv
